### hdl/cfvc_pkg.sv
// Package with the word types, mode codes and default sizes of the CNF vote classifier.
`timescale 1ns / 1ps

package cfvc_pkg;

    localparam int NUM_CLASSES_DEF         = 8;
    localparam int FORMULAS_PER_SET_DEF    = 16;
    localparam int CLAUSES_PER_FORMULA_DEF = 8;
    localparam int NUM_ATTRS_DEF           = 64;

    localparam logic [1:0] MODE_CLAUSE  = 2'd0;
    localparam logic [1:0] MODE_CCOUNT  = 2'd1;
    localparam logic [1:0] MODE_FCOUNT  = 2'd2;
    localparam logic [1:0] MODE_CLASSIFY = 2'd3;

    localparam logic [3:0] CLASSES_IN_USE_RST = 4'd8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  class_sel;
        logic        polarity;
        logic [3:0]  formula_index;
        logic [2:0]  clause_index;
        logic [4:0]  count_value;
        logic [63:0] pos_mask;
        logic [63:0] neg_mask;
        logic [63:0] row_bits;
    } t_in_word;

    typedef struct packed {
        logic [2:0] winner_class;
        logic [5:0] winner_score;
    } t_out_word;

endpackage

### hdl/cnf_formula_vote_classifier_top.sv
// Top level of the CNF vote classifier: clause memories, count stores and the scoring walk.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake               Word
//  in       input      i_in_valid/o_in_ready   t_in_word (load or classify)
//  out      output     o_out_valid/i_out_ready t_out_word (one per classify)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (classes_in_use)
//
//  A load word is written to its memory as it is taken. A classify word walks, per class in
//  use, both polarity sets; per formula it reads the clause count and then the clauses one
//  at a time until one fails or the last is read, as the clause memory has a single read port.
//  Then the result is registered; the finish stalls while the previous result still waits.
//  After reset the clause count memory is cleared, one entry a cycle, through all
//  2*NUM_CLASSES*FORMULAS_PER_SET entries (256 by default); no word is taken meanwhile.
//  A finished result waits in the output register while the next word is taken.

module cnf_formula_vote_classifier_top
    import cfvc_pkg::*;
#(
    parameter int NUM_CLASSES         = NUM_CLASSES_DEF,
    parameter int FORMULAS_PER_SET    = FORMULAS_PER_SET_DEF,
    parameter int CLAUSES_PER_FORMULA = CLAUSES_PER_FORMULA_DEF,
    parameter int NUM_ATTRS           = NUM_ATTRS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    localparam int SETS    = 2 * NUM_CLASSES;
    localparam int FSLOTS  = SETS * FORMULAS_PER_SET;
    localparam int CSLOTS  = FSLOTS * CLAUSES_PER_FORMULA;
    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int LIM_W   = $clog2(NUM_CLASSES + 1);
    localparam int FI_W    = $clog2(FORMULAS_PER_SET + 1);
    localparam int CI_W    = (CLAUSES_PER_FORMULA > 1) ? $clog2(CLAUSES_PER_FORMULA) : 1;
    localparam int FC_W    = $clog2(FORMULAS_PER_SET + 1);
    localparam int CC_W    = $clog2(CLAUSES_PER_FORMULA + 1);
    localparam int FS_W    = $clog2(FSLOTS);
    localparam int CS_W    = $clog2(CSLOTS);
    localparam int SC_W    = $clog2(2 * FORMULAS_PER_SET + 1);
    localparam logic [63:0] ATTR_MASK = {64{1'b1}} >> (64 - NUM_ATTRS);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SET  = 3'd2;
    localparam logic [2:0] S_CCNT = 3'd3;
    localparam logic [2:0] S_CL   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Clause memory holds {pos, neg}; clause count memory is cleared after reset.
    logic [2*NUM_ATTRS-1:0] r_cl_mem [CSLOTS];
    logic [CC_W-1:0]        r_cc_mem [FSLOTS];
    logic [FC_W-1:0]        r_fcnt   [SETS];

    logic [2:0]             r_state, n_state;
    logic [FS_W-1:0]        r_clr, n_clr;
    logic [3:0]             r_cfg;
    logic [LIM_W-1:0]       r_limit, n_limit;
    logic [CLS_W-1:0]       r_cls, n_cls;
    logic                   r_pol, n_pol;
    logic [FI_W-1:0]        r_fi, n_fi;
    logic [CI_W-1:0]        r_ci, n_ci;
    logic [CC_W-1:0]        r_ncl, n_ncl;
    logic [SC_W-1:0]        r_score, n_score;
    logic [SC_W-1:0]        r_best_score, n_best_score;
    logic [CLS_W-1:0]       r_best, n_best;
    logic [NUM_ATTRS-1:0]   r_row, n_row;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out, n_out;
    logic [2*NUM_ATTRS-1:0] r_cl_rd;
    logic [CC_W-1:0]        r_cc_rd;

    logic                   w_acc;
    logic                   w_cls_ok, w_fi_ok, w_ci_ok;
    logic [CLS_W:0]         w_ld_set;
    logic [FS_W-1:0]        w_ld_fslot;
    logic [CS_W-1:0]        w_ld_cslot;
    logic [FS_W-1:0]        w_fslot;
    logic [CI_W-1:0]        w_rd_ci;
    logic [CS_W-1:0]        w_cl_raddr;
    logic                   w_cc_we;
    logic [FS_W-1:0]        w_cc_waddr;
    logic [CC_W-1:0]        w_cc_wdata;
    logic                   w_cl_we;
    logic                   w_fc_we;
    logic [FC_W-1:0]        w_fc_wdata;
    logic [FC_W-1:0]        w_nf;
    logic                   w_clause_ok;
    logic                   w_last_cl;
    logic [SC_W-1:0]        w_score_inc;
    logic [CLS_W:0]         w_set;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign w_acc       = i_in_valid && o_in_ready;

    // Load address decode.
    assign w_cls_ok   = int'(i_in_word.class_sel) < NUM_CLASSES;
    assign w_fi_ok    = int'(i_in_word.formula_index) < FORMULAS_PER_SET;
    assign w_ci_ok    = int'(i_in_word.clause_index) < CLAUSES_PER_FORMULA;
    assign w_ld_set   = {CLS_W'(i_in_word.class_sel), i_in_word.polarity};
    assign w_ld_fslot = FS_W'(int'(w_ld_set) * FORMULAS_PER_SET
                              + int'(i_in_word.formula_index));
    assign w_ld_cslot = CS_W'(int'(w_ld_fslot) * CLAUSES_PER_FORMULA
                              + int'(i_in_word.clause_index));

    assign w_cl_we = w_acc && (i_in_word.mode == MODE_CLAUSE) && w_cls_ok && w_fi_ok && w_ci_ok;
    assign w_fc_we = w_acc && (i_in_word.mode == MODE_FCOUNT) && w_cls_ok;
    assign w_fc_wdata = (int'(i_in_word.count_value) > FORMULAS_PER_SET)
                        ? FC_W'(FORMULAS_PER_SET) : FC_W'(i_in_word.count_value);

    always_comb begin
        w_cc_we    = 1'b0;
        w_cc_waddr = w_ld_fslot;
        w_cc_wdata = (int'(i_in_word.count_value) > CLAUSES_PER_FORMULA)
                     ? CC_W'(CLAUSES_PER_FORMULA) : CC_W'(i_in_word.count_value);
        if (r_state == S_CLR) begin
            w_cc_we    = 1'b1;
            w_cc_waddr = r_clr;
            w_cc_wdata = '0;
        end else if (w_acc && (i_in_word.mode == MODE_CCOUNT) && w_cls_ok && w_fi_ok) begin
            w_cc_we = 1'b1;
        end
    end

    // Walk addressing: writes happen only in idle, so the walk never reads a pending entry.
    assign w_set       = {r_cls, r_pol};
    assign w_nf        = r_fcnt[w_set];
    assign w_fslot     = FS_W'(int'(w_set) * FORMULAS_PER_SET + int'(r_fi));
    assign w_last_cl   = (int'(r_ci) + 1 == int'(r_ncl));
    assign w_rd_ci     = (r_state == S_CL && !w_last_cl) ? CI_W'(int'(r_ci) + 1) : '0;
    assign w_cl_raddr  = CS_W'(int'(w_fslot) * CLAUSES_PER_FORMULA + int'(w_rd_ci));
    assign w_clause_ok = |((r_row & r_cl_rd[2*NUM_ATTRS-1:NUM_ATTRS])
                           | (~r_row & r_cl_rd[NUM_ATTRS-1:0]));
    assign w_score_inc = SC_W'(int'(r_score) + 1);

    always_ff @(posedge i_clk) begin
        if (w_cl_we) begin
            r_cl_mem[w_ld_cslot] <= {i_in_word.pos_mask[NUM_ATTRS-1:0] & ATTR_MASK[NUM_ATTRS-1:0],
                                     i_in_word.neg_mask[NUM_ATTRS-1:0] & ATTR_MASK[NUM_ATTRS-1:0]};
        end
        r_cl_rd <= r_cl_mem[w_cl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cc_we) begin
            r_cc_mem[w_cc_waddr] <= w_cc_wdata;
        end
        r_cc_rd <= r_cc_mem[w_fslot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SETS; i++) begin
                r_fcnt[i] <= '0;
            end
        end else if (w_fc_we) begin
            r_fcnt[w_ld_set] <= w_fc_wdata;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_limit      = r_limit;
        n_cls        = r_cls;
        n_pol        = r_pol;
        n_fi         = r_fi;
        n_ci         = r_ci;
        n_ncl        = r_ncl;
        n_score      = r_score;
        n_best_score = r_best_score;
        n_best       = r_best;
        n_row        = r_row;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        case (r_state)
            S_CLR: begin
                n_clr = FS_W'(int'(r_clr) + 1);
                if (int'(r_clr) == FSLOTS - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc && i_in_word.mode == MODE_CLASSIFY) begin
                    n_row        = i_in_word.row_bits[NUM_ATTRS-1:0];
                    n_limit      = (int'(r_cfg) > NUM_CLASSES) ? LIM_W'(NUM_CLASSES)
                                                               : LIM_W'(r_cfg);
                    n_cls        = '0;
                    n_pol        = 1'b0;
                    n_fi         = '0;
                    n_score      = '0;
                    n_best       = '0;
                    n_best_score = '0;
                    n_state      = (n_limit == '0) ? S_DONE : S_SET;
                end
            end
            S_SET: begin
                if (int'(r_fi) >= int'(w_nf)) begin
                    n_fi = '0;
                    if (!r_pol) begin
                        n_pol = 1'b1;
                    end else begin
                        // End of a class: first strictly higher score wins.
                        n_pol   = 1'b0;
                        n_score = '0;
                        if (r_score > r_best_score) begin
                            n_best_score = r_score;
                            n_best       = r_cls;
                        end
                        if (int'(r_cls) + 1 == int'(r_limit)) begin
                            n_state = S_DONE;
                        end else begin
                            n_cls = CLS_W'(int'(r_cls) + 1);
                        end
                    end
                end else begin
                    n_state = S_CCNT;
                end
            end
            S_CCNT: begin
                n_ncl = r_cc_rd;
                n_ci  = '0;
                if (r_cc_rd == '0) begin
                    n_fi    = FI_W'(int'(r_fi) + 1);
                    n_state = S_SET;
                    if (!r_pol) begin
                        n_score = w_score_inc;
                    end
                end else begin
                    n_state = S_CL;
                end
            end
            S_CL: begin
                if (!w_clause_ok || w_last_cl) begin
                    n_fi    = FI_W'(int'(r_fi) + 1);
                    n_state = S_SET;
                    // A positive formula scores when it holds, a negative one when it fails.
                    if (w_clause_ok != r_pol) begin
                        n_score = w_score_inc;
                    end
                end else begin
                    n_ci = CI_W'(int'(r_ci) + 1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out.winner_class      = 3'(r_best);
                    n_out.winner_score      = (int'(r_best_score) > 63) ? 6'd63
                                                                       : 6'(r_best_score);
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_cfg       <= CLASSES_IN_USE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit      <= n_limit;
        r_cls        <= n_cls;
        r_pol        <= n_pol;
        r_fi         <= n_fi;
        r_ci         <= n_ci;
        r_ncl        <= n_ncl;
        r_score      <= n_score;
        r_best_score <= n_best_score;
        r_best       <= n_best;
        r_row        <= n_row;
        r_out        <= n_out;
    end

    a_clr_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_in_ready)
        else $error("word taken during clause count clearing");

    a_clause_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CL) |-> (int'(r_ci) < int'(r_ncl)))
        else $error("clause index beyond clause count");

    a_walk_class_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SET || r_state == S_CCNT || r_state == S_CL)
            |-> (int'(r_cls) < int'(r_limit)))
        else $error("walk class beyond classes in use");

    a_score_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (int'(r_best_score) <= 2 * FORMULAS_PER_SET))
        else $error("winning score above formula total");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=> r_out_valid)
        else $error("finished classify did not reach the output register");

endmodule

### tb/cnf_formula_vote_classifier_top_tb.sv
// Self-checking testbench of the CNF vote classifier: directed table, random loads and votes.
`timescale 1ns / 1ps

module cnf_formula_vote_classifier_top_tb;
    import cfvc_pkg::*;

    localparam int PHASE_ITEMS = 300;
    localparam int DRAIN_CYCLES = 3000;

    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word vote;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [3:0] i_cfg_data = 4'd0;

    // Shadow copy of the classifier state.
    logic [63:0] pos_shadow [2048];
    logic [63:0] neg_shadow [2048];
    bit          clause_written [2048];
    logic [3:0]  ccount_shadow [256];
    logic [4:0]  fcount_shadow [16];
    logic [3:0]  classes_shadow = CLASSES_IN_USE_RST;

    t_out_word   pending_votes [$];
    t_dir_row    dir_rows [$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          votes_seen = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    cnf_formula_vote_classifier_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int clause_key(int cls, int pol, int fi, int ci);
        return ((cls * 2 + pol) * 16 + fi) * 8 + ci;
    endfunction

    function automatic t_out_word vote_for_row(logic [63:0] row);
        int lim, best, best_score, score, fslot, k;
        bit holds;
        t_out_word r;
        lim = (classes_shadow > 8) ? 8 : classes_shadow;
        best = 0;
        best_score = 0;
        for (int cls = 0; cls < lim; cls++) begin
            score = 0;
            for (int pol = 0; pol < 2; pol++) begin
                for (int f = 0; f < fcount_shadow[cls * 2 + pol]; f++) begin
                    fslot = (cls * 2 + pol) * 16 + f;
                    holds = 1'b1;
                    for (int c = 0; c < ccount_shadow[fslot]; c++) begin
                        k = fslot * 8 + c;
                        if (((row & pos_shadow[k]) | (~row & neg_shadow[k])) == 64'd0)
                            holds = 1'b0;
                    end
                    if (holds == (pol == 0))
                        score++;
                end
            end
            if (score > best_score) begin
                best_score = score;
                best = cls;
            end
        end
        r.winner_class = best[2:0];
        r.winner_score = (best_score > 63) ? 6'd63 : best_score[5:0];
        return r;
    endfunction

    function automatic void apply_load(t_in_word w);
        int k, fslot;
        fslot = (w.class_sel * 2 + w.polarity) * 16 + w.formula_index;
        case (w.mode)
            MODE_CLAUSE: begin
                k = fslot * 8 + w.clause_index;
                pos_shadow[k] = w.pos_mask;
                neg_shadow[k] = w.neg_mask;
                clause_written[k] = 1'b1;
            end
            MODE_CCOUNT: ccount_shadow[fslot] = (w.count_value > 8) ? 4'd8 : w.count_value[3:0];
            MODE_FCOUNT: fcount_shadow[w.class_sel * 2 + w.polarity] =
                (w.count_value > 16) ? 5'd16 : w.count_value;
            default: ;
        endcase
    endfunction

    function automatic t_in_word make_word(logic [1:0] mode, int cls, int pol, int fi, int ci,
                                           int cnt, logic [63:0] pm, logic [63:0] nm,
                                           logic [63:0] row);
        t_in_word w;
        w.mode = mode;
        w.class_sel = cls[2:0];
        w.polarity = pol[0];
        w.formula_index = fi[3:0];
        w.clause_index = ci[2:0];
        w.count_value = cnt[4:0];
        w.pos_mask = pm;
        w.neg_mask = nm;
        w.row_bits = row;
        return w;
    endfunction

    // Sparse masks keep clauses near the point where they flip between holding and failing.
    function automatic logic [63:0] random_bits();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return '1;
            2, 3: return {$urandom, $urandom};
            default: return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
        endcase
    endfunction

    task automatic send_word(t_in_word w, bit typed = 1'b0, t_out_word vote = '0);
        i_in_word <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        if (w.mode == MODE_CLASSIFY)
            pending_votes.push_back(typed ? vote : vote_for_row(w.row_bits));
        else
            apply_load(w);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            while ($urandom_range(99) < idle_pct)
                @(posedge i_clk);
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_votes.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_classes(logic [3:0] value);
        wait_idle();
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        classes_shadow = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes the clauses a count will reach before setting the count itself.
    task automatic program_formula();
        int cls, pol, fi, cnt, n, k;
        cls = $urandom_range(7);
        pol = $urandom_range(1);
        fi = $urandom_range(15);
        cnt = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(4);
        n = (cnt > 8) ? 8 : cnt;
        for (int c = 0; c < n; c++) begin
            k = clause_key(cls, pol, fi, c);
            if (!clause_written[k] || $urandom_range(2) == 0)
                send_word(make_word(MODE_CLAUSE, cls, pol, fi, c, $urandom_range(31),
                                    random_bits(), random_bits(), random_bits()));
        end
        send_word(make_word(MODE_CCOUNT, cls, pol, fi, $urandom_range(7), cnt,
                            random_bits(), random_bits(), random_bits()));
    endtask

    task automatic random_word();
        int pick, cnt;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_word(make_word(MODE_CLASSIFY, $urandom_range(7), $urandom_range(1),
                                $urandom_range(15), $urandom_range(7), $urandom_range(31),
                                random_bits(), random_bits(), random_bits()));
        end else if (pick < 72) begin
            program_formula();
        end else if (pick < 90) begin
            cnt = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(5);
            send_word(make_word(MODE_FCOUNT, $urandom_range(7), $urandom_range(1),
                                $urandom_range(15), $urandom_range(7), cnt,
                                random_bits(), random_bits(), random_bits()));
        end else begin
            send_word(make_word(MODE_CLAUSE, $urandom_range(7), $urandom_range(1),
                                $urandom_range(15), $urandom_range(7), $urandom_range(31),
                                random_bits(), random_bits(), random_bits()));
        end
    endtask

    function automatic void add_row(t_in_word w, bit typed = 1'b0, int cls = 0, int score = 0);
        t_dir_row r;
        r.word = w;
        r.typed = typed;
        r.vote.winner_class = cls[2:0];
        r.vote.winner_score = score[5:0];
        dir_rows.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            votes_seen++;
            if (pending_votes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected vote: class %0d score %0d",
                             o_out_word.winner_class, o_out_word.winner_score);
            end else begin
                t_out_word exp_vote;
                exp_vote = pending_votes.pop_front();
                if (o_out_word.winner_class !== exp_vote.winner_class ||
                    o_out_word.winner_score !== exp_vote.winner_score) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Vote mismatch: expected class %0d score %0d, got class %0d score %0d",
                                 exp_vote.winner_class, exp_vote.winner_score,
                                 o_out_word.winner_class, o_out_word.winner_score);
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        logic [3:0] cfg_values [6];
        int stall_table [4];
        int idle_table [4];
        int waited;

        cfg_values = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        idle_table = '{0, 86, 0, 11};
        stall_table = '{0, 0, 86, 11};
        for (int k = 0; k < 256; k++) ccount_shadow[k] = 4'd0;
        for (int k = 0; k < 16; k++) fcount_shadow[k] = 5'd0;
        for (int k = 0; k < 2048; k++) begin
            pos_shadow[k] = '0;
            neg_shadow[k] = '0;
            clause_written[k] = 1'b0;
        end

        // Empty formulas hold; an empty clause makes its formula fail.
        add_row(make_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, '0, '0, '0), 1'b1, 0, 0);
        add_row(make_word(MODE_CLASSIFY, 7, 1, 15, 7, 31, '1, '1, '1), 1'b1, 0, 0);
        add_row(make_word(MODE_FCOUNT, 0, 0, 0, 0, 16, '0, '0, '0));
        add_row(make_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, '0, '0, 64'h5555_aaaa_0f0f_f0f0), 1'b1, 0, 16);
        add_row(make_word(MODE_FCOUNT, 1, 0, 0, 0, 31, '0, '0, '0));
        add_row(make_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, '0, '0, '1), 1'b1, 0, 16);
        add_row(make_word(MODE_CLAUSE, 2, 1, 0, 0, 0, '0, '0, '0));
        add_row(make_word(MODE_CCOUNT, 2, 1, 0, 0, 1, '0, '0, '0));
        add_row(make_word(MODE_FCOUNT, 2, 1, 0, 0, 1, '0, '0, '0));
        add_row(make_word(MODE_FCOUNT, 2, 0, 0, 0, 16, '0, '0, '0));
        add_row(make_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, '0, '0, '0), 1'b1, 2, 17);
        add_row(make_word(MODE_CLAUSE, 7, 0, 0, 0, 0, '1, '0, '0));
        add_row(make_word(MODE_CCOUNT, 7, 0, 0, 0, 1, '0, '0, '0));
        add_row(make_word(MODE_FCOUNT, 7, 0, 0, 0, 1, '0, '0, '0));
        add_row(make_word(MODE_CLAUSE, 7, 1, 15, 7, 31, '0, '1, '0));
        add_row(make_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, '0, '0, '0));
        add_row(make_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, '0, '0, 64'h8000_0000_0000_0001));
        add_row(make_word(MODE_FCOUNT, 0, 0, 0, 0, 0, '0, '0, '0));
        add_row(make_word(MODE_FCOUNT, 1, 0, 0, 0, 0, '0, '0, '0));
        add_row(make_word(MODE_CLASSIFY, 0, 0, 0, 0, 0, '0, '0, '1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_word(dir_rows[r].word, dir_rows[r].typed, dir_rows[r].vote);

        for (int p = 0; p < 6; p++) begin
            idle_pct = 0;
            write_classes((p == 5) ? 4'($urandom_range(2, 7)) : cfg_values[p]);
            idle_pct = idle_table[p % 4];
            stall_pct = stall_table[p % 4];
            for (int n = words_sent + PHASE_ITEMS; words_sent < n; ) begin
                random_word();
                if (p == 1 && words_sent == n - PHASE_ITEMS / 2)
                    wait_idle();
            end
        end

        i_in_valid <= 1'b0;
        stall_pct = 0;
        waited = 0;
        while (pending_votes.size() != 0 && waited < 1_000_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words and checked %0d votes over six class settings,", words_sent,
                 votes_seen);
        $display("with sender gaps and receiver stalls; %0d mismatches.", mismatches);
        if (mismatches == 0 && pending_votes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/cfvc_pkg.sv
hdl/cnf_formula_vote_classifier_top.sv
tb/cnf_formula_vote_classifier_top_tb.sv
